// ===== rtl/bco_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bco_pkg
// Shared types, field widths and codes of the bounded-confidence opinion step.
// ----------------------------------------------------------------------------
package bco_pkg;

   localparam int MAX_AGENTS_DEF   = 1024;
   localparam int MAX_OPINIONS_DEF = 64;
   localparam int RANDOM_BITS_DEF  = 16;

   localparam int CMD_W    = 2;
   localparam int AGENT_W  = 10;
   localparam int OPIN_W   = 7;
   localparam int RAND_W   = 16;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 11;
   localparam int NAG_W    = 11;
   localparam int TOL_W    = 6;
   localparam int BIAS_W   = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CNT_W-1:0] COUNT_MAX = 11'h7FF;

   localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FINISH   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INTERACT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INACTIVE     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INCOMPATIBLE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_AGENTS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_OPINIONS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_MODE    = 2'd3;

   localparam logic [BIAS_W-1:0] BIAS_PAIRWISE = 2'd1;
   localparam logic [BIAS_W-1:0] BIAS_GLOBAL   = 2'd2;

   localparam logic [NAG_W-1:0]  NUM_AGENTS_RST   = 11'd1024;
   localparam logic [OPIN_W-1:0] NUM_OPINIONS_RST = 7'd64;
   localparam logic [TOL_W-1:0]  TOLERANCE_RST    = 6'd1;
   localparam logic [BIAS_W-1:0] BIAS_MODE_RST    = 2'd0;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [AGENT_W-1:0] first_agent;
      logic [AGENT_W-1:0] second_agent;
      logic [OPIN_W-1:0]  load_opinion;
      logic [RAND_W-1:0]  random_fraction;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [AGENT_W-1:0]  winner_agent;
      logic [AGENT_W-1:0]  loser_agent;
      logic [OPIN_W-1:0]   adopted_opinion;
      logic                opinion_vanished;
      logic                steady;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LD_WR,
      S_AG_CHK,
      S_LATCH,
      S_MUL,
      S_WIN,
      S_LOSE,
      S_SCAN,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/bco_agent_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bco_agent_mem
// Agent opinion store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bco_agent_mem #(
   parameter int DEPTH = bco_pkg::MAX_AGENTS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [bco_pkg::OPIN_W-1:0] wr_data,
   input  wire logic [AW-1:0]             rd_addr_a,
   input  wire logic [AW-1:0]             rd_addr_b,
   output logic      [bco_pkg::OPIN_W-1:0] rd_data_a,
   output logic      [bco_pkg::OPIN_W-1:0] rd_data_b
);

   logic [bco_pkg::OPIN_W-1:0] mem_ff [DEPTH];
   logic [bco_pkg::OPIN_W-1:0] rd_a_ff;
   logic [bco_pkg::OPIN_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

// ===== rtl/bco_cnt_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bco_cnt_mem
// Opinion count store with per-entry nonzero flags; unflagged entries read 0.
// ----------------------------------------------------------------------------
module bco_cnt_mem #(
   parameter int DEPTH = bco_pkg::MAX_OPINIONS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [bco_pkg::CNT_W-1:0]  wr_data,
   input  wire logic [AW-1:0]              rd_addr_a,
   input  wire logic [AW-1:0]              rd_addr_b,
   output logic      [bco_pkg::CNT_W-1:0]  rd_data_a,
   output logic      [bco_pkg::CNT_W-1:0]  rd_data_b,
   output logic      [DEPTH-1:0]           nonzero
);

   logic [bco_pkg::CNT_W-1:0] mem_ff [DEPTH];
   logic [bco_pkg::CNT_W-1:0] rd_a_ff;
   logic [bco_pkg::CNT_W-1:0] rd_b_ff;
   logic                      rd_nz_a_ff;
   logic                      rd_nz_b_ff;
   logic [DEPTH-1:0]          nz_ff;
   logic [DEPTH-1:0]          nz_in;

   always_comb begin
      nz_in = nz_ff;
      if (wr_en) begin
         nz_in[wr_addr] = (wr_data != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nz_ff <= '0;
      end else begin
         nz_ff <= nz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff    <= mem_ff[rd_addr_a];
      rd_b_ff    <= mem_ff[rd_addr_b];
      rd_nz_a_ff <= nz_ff[rd_addr_a];
      rd_nz_b_ff <= nz_ff[rd_addr_b];
   end

   assign rd_data_a = rd_nz_a_ff ? rd_a_ff : '0;
   assign rd_data_b = rd_nz_b_ff ? rd_b_ff : '0;
   assign nonzero   = nz_ff;

endmodule
`default_nettype wire

// ===== rtl/bounded_confidence_opinion_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_confidence_opinion_step
// Agent-based bounded-confidence opinion step: load, finish and interact items.
// ----------------------------------------------------------------------------
// One item at a time under a small sequencer. A load writes the agent store,
// then raises its opinion's count. An interaction reads and checks both agents,
// reads their counts, forms a product in one shared multiplier for the winner
// compare, writes the loser's opinion and the winner's count, then lowers the
// loser's count. An agent index out of range, a bad load or an unknown command
// goes straight to the response. A finish item, and an interaction that empties
// an opinion, walk all MAX_OPINIONS opinions, one opinion per cycle. The count
// store is cleared at reset through per-entry nonzero flags, with no clearing pass.
// A result register lets a finished item wait on rsp_ready while the block idles.
module bounded_confidence_opinion_step #(
   parameter int MAX_AGENTS   = bco_pkg::MAX_AGENTS_DEF,
   parameter int MAX_OPINIONS = bco_pkg::MAX_OPINIONS_DEF,
   parameter int RANDOM_BITS  = bco_pkg::RANDOM_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire bco_pkg::req_type                    req_item,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output bco_pkg::rsp_type                         rsp_item,
   input  wire logic                                csr_we,
   input  wire logic [bco_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bco_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AAW = $clog2(MAX_AGENTS);
   localparam int OAW = $clog2(MAX_OPINIONS);
   localparam int SW  = ((OAW + 1) > 7 ? (OAW + 1) : 7) + 1;
   localparam int MW  = bco_pkg::CNT_W + 1;
   localparam int PW  = RANDOM_BITS + MW;
   localparam logic [OAW-1:0] SCAN_LAST = OAW'(MAX_OPINIONS - 1);

   localparam int OW  = bco_pkg::OPIN_W;
   localparam int CW  = bco_pkg::CNT_W;
   localparam int AGW = bco_pkg::AGENT_W;

   // configuration
   logic [bco_pkg::NAG_W-1:0]  num_agents_ff;
   logic [OW-1:0]              num_opinions_ff;
   logic [bco_pkg::TOL_W-1:0]  tol_ff;
   logic [bco_pkg::BIAS_W-1:0] bias_ff;
   logic [bco_pkg::NAG_W-1:0]  n_eff;
   logic [OW-1:0]              q_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_agents_ff   <= bco_pkg::NUM_AGENTS_RST;
         num_opinions_ff <= bco_pkg::NUM_OPINIONS_RST;
         tol_ff          <= bco_pkg::TOLERANCE_RST;
         bias_ff         <= bco_pkg::BIAS_MODE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bco_pkg::CSR_NUM_AGENTS:   num_agents_ff   <= csr_wdata;
            bco_pkg::CSR_NUM_OPINIONS: num_opinions_ff <= csr_wdata[OW-1:0];
            bco_pkg::CSR_TOLERANCE:    tol_ff          <= csr_wdata[bco_pkg::TOL_W-1:0];
            bco_pkg::CSR_BIAS_MODE:    bias_ff         <= csr_wdata[bco_pkg::BIAS_W-1:0];
            default: ;
         endcase
      end
   end

   assign n_eff = (32'(num_agents_ff) > MAX_AGENTS) ? bco_pkg::NAG_W'(MAX_AGENTS)
                                                    : num_agents_ff;
   assign q_eff = (32'(num_opinions_ff) > MAX_OPINIONS) ? OW'(MAX_OPINIONS)
                                                        : num_opinions_ff;

   // sequencer state
   bco_pkg::state_type state_ff, state_in;
   bco_pkg::req_type   item_ff, item_in;
   logic [bco_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [AGW-1:0] win_ff, win_in, lose_ff, lose_in;
   logic [OW-1:0]  adopt_ff, adopt_in, q1_ff, q1_in, q2_ff, q2_in;
   logic           van_ff, van_in;
   logic [CW-1:0]  n1_ff, n1_in, n2_ff, n2_in;
   logic [MW-1:0]  m_ff, m_in;
   logic [PW-1:0]  prod_ff, prod_in;
   logic           fw_ff, fw_in;
   logic [OAW-1:0] scan_idx_ff, scan_idx_in;
   logic           any_ff, any_in, steady_ff, steady_in;
   logic [MAX_OPINIONS-1:0] active_ff, active_in;
   logic           rsp_valid_ff, rsp_valid_in;
   bco_pkg::rsp_type rsp_item_ff, rsp_item_in;

   // store ports
   logic           ag_we;
   logic [AAW-1:0] ag_waddr, ag_raddr_a, ag_raddr_b;
   logic [OW-1:0]  ag_wdata, ag_q1, ag_q2;
   logic           cnt_we;
   logic [OAW-1:0] cnt_waddr, cnt_raddr_a, cnt_raddr_b;
   logic [CW-1:0]  cnt_wdata, cnt_n1, cnt_n2;
   logic [MAX_OPINIONS-1:0] nz;

   bco_agent_mem #(.DEPTH(MAX_AGENTS), .AW(AAW)) u_agent_mem (
      .clock(clock), .wr_en(ag_we), .wr_addr(ag_waddr), .wr_data(ag_wdata),
      .rd_addr_a(ag_raddr_a), .rd_addr_b(ag_raddr_b),
      .rd_data_a(ag_q1), .rd_data_b(ag_q2)
   );

   bco_cnt_mem #(.DEPTH(MAX_OPINIONS), .AW(OAW)) u_cnt_mem (
      .clock(clock), .reset(reset), .wr_en(cnt_we), .wr_addr(cnt_waddr),
      .wr_data(cnt_wdata), .rd_addr_a(cnt_raddr_a), .rd_addr_b(cnt_raddr_b),
      .rd_data_a(cnt_n1), .rd_data_b(cnt_n2), .nonzero(nz)
   );

   // datapath helpers
   logic             req_fire;
   logic             ld_bad, ia_bad;
   logic [RANDOM_BITS-1:0] r_val;
   logic             unbiased_fw, pair_fw, major_fw;
   logic [CW-1:0]    cnt_diff;
   logic [PW-1:0]    rhs_pair, rhs_major;
   logic [OW:0]      hi_sum;
   logic [OW-1:0]    lo_b, hi_b;
   logic             q1_bad, q2_bad;
   logic [CW-1:0]    nw, nl, nl_dec;
   logic [OW-1:0]    qw, ql;
   logic [SW-1:0]    scan_i;
   logic [MAX_OPINIONS-1:0] win_mask;
   logic             scan_act;

   assign req_ready = (state_ff == bco_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign ld_bad = ({1'b0, req_item.first_agent} >= n_eff) ||
                   (req_item.load_opinion == '0) || (req_item.load_opinion > q_eff);
   assign ia_bad = ({1'b0, req_item.first_agent} >= n_eff) ||
                   ({1'b0, req_item.second_agent} >= n_eff);

   assign r_val       = RANDOM_BITS'(item_ff.random_fraction);
   assign unbiased_fw = !r_val[RANDOM_BITS-1];
   assign cnt_diff    = (n1_ff > n2_ff) ? (n1_ff - n2_ff) : (n2_ff - n1_ff);
   assign rhs_pair    = PW'(n1_ff) << RANDOM_BITS;
   assign rhs_major   = PW'({1'b0, n_eff} + {1'b0, cnt_diff}) << RANDOM_BITS;
   assign pair_fw     = prod_ff < rhs_pair;
   assign major_fw    = (n1_ff > n2_ff) ? (prod_ff < rhs_major) : !(prod_ff < rhs_major);

   // partner window around the first agent's opinion
   assign hi_sum = {1'b0, ag_q1} + (OW+1)'(tol_ff);
   assign lo_b   = (ag_q1 > OW'(tol_ff)) ? (ag_q1 - OW'(tol_ff)) : OW'(1);
   assign hi_b   = (hi_sum < {1'b0, q_eff}) ? hi_sum[OW-1:0] : q_eff;
   assign q1_bad = (ag_q1 == '0) || (ag_q1 > q_eff) ||
                   !active_ff[OAW'(ag_q1 - OW'(1))];
   assign q2_bad = (item_ff.first_agent == item_ff.second_agent) ||
                   (ag_q2 == ag_q1) || (ag_q2 < lo_b) || (ag_q2 > hi_b);

   assign nw     = fw_in ? n1_ff : n2_ff;
   assign qw     = fw_in ? q1_ff : q2_ff;
   assign nl     = fw_ff ? n2_ff : n1_ff;
   assign ql     = fw_ff ? q2_ff : q1_ff;
   assign nl_dec = (nl == '0) ? '0 : (nl - CW'(1));

   // activity of one opinion against its tolerance window
   assign scan_i = SW'(scan_idx_ff) + SW'(1);
   always_comb begin
      for (int j = 0; j < MAX_OPINIONS; j++) begin
         win_mask[j] = nz[j] && (SW'(j) + SW'(1) <= SW'(q_eff)) &&
                       (SW'(j) != SW'(scan_idx_ff)) &&
                       (SW'(j) + SW'(1) + SW'(tol_ff) >= scan_i) &&
                       (SW'(j) + SW'(1) <= scan_i + SW'(tol_ff));
      end
   end
   assign scan_act = (scan_i <= SW'(q_eff)) && nz[scan_idx_ff] && (|win_mask);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      status_in    = status_ff;
      win_in       = win_ff;
      lose_in      = lose_ff;
      adopt_in     = adopt_ff;
      van_in       = van_ff;
      q1_in        = q1_ff;
      q2_in        = q2_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      m_in         = m_ff;
      prod_in      = prod_ff;
      fw_in        = fw_ff;
      scan_idx_in  = scan_idx_ff;
      any_in       = any_ff;
      steady_in    = steady_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      ag_we        = 1'b0;
      ag_waddr     = AAW'(req_item.first_agent);
      ag_wdata     = req_item.load_opinion;
      ag_raddr_a   = AAW'(req_item.first_agent);
      ag_raddr_b   = AAW'(req_item.second_agent);
      cnt_we       = 1'b0;
      cnt_waddr    = OAW'(item_ff.load_opinion - OW'(1));
      cnt_wdata    = (cnt_n1 == bco_pkg::COUNT_MAX) ? cnt_n1 : (cnt_n1 + CW'(1));
      cnt_raddr_a  = OAW'(req_item.load_opinion - OW'(1));
      cnt_raddr_b  = OAW'(ag_q2 - OW'(1));

      unique case (state_ff)
         bco_pkg::S_IDLE: begin
            if (req_fire) begin
               item_in   = req_item;
               status_in = bco_pkg::ST_DONE;
               win_in    = '0;
               lose_in   = '0;
               adopt_in  = '0;
               van_in    = 1'b0;
               unique case (req_item.cmd)
                  bco_pkg::CMD_LOAD: begin
                     if (ld_bad) begin
                        status_in = bco_pkg::ST_RANGE;
                        state_in  = bco_pkg::S_RESP;
                     end else begin
                        ag_we    = 1'b1;
                        lose_in  = req_item.first_agent;
                        adopt_in = req_item.load_opinion;
                        state_in = bco_pkg::S_LD_WR;
                     end
                  end
                  bco_pkg::CMD_FINISH: begin
                     scan_idx_in = '0;
                     any_in      = 1'b0;
                     state_in    = bco_pkg::S_SCAN;
                  end
                  bco_pkg::CMD_INTERACT: begin
                     if (ia_bad) begin
                        status_in = bco_pkg::ST_RANGE;
                        state_in  = bco_pkg::S_RESP;
                     end else begin
                        state_in = bco_pkg::S_AG_CHK;
                     end
                  end
                  default: begin
                     status_in = bco_pkg::ST_RANGE;
                     state_in  = bco_pkg::S_RESP;
                  end
               endcase
            end
         end
         bco_pkg::S_LD_WR: begin
            cnt_we   = 1'b1;
            state_in = bco_pkg::S_RESP;
         end
         bco_pkg::S_AG_CHK: begin
            q1_in       = ag_q1;
            q2_in       = ag_q2;
            cnt_raddr_a = OAW'(ag_q1 - OW'(1));
            if (q1_bad) begin
               status_in = bco_pkg::ST_INACTIVE;
               state_in  = bco_pkg::S_RESP;
            end else if (q2_bad) begin
               status_in = bco_pkg::ST_INCOMPATIBLE;
               state_in  = bco_pkg::S_RESP;
            end else begin
               state_in = bco_pkg::S_LATCH;
            end
         end
         bco_pkg::S_LATCH: begin
            n1_in    = cnt_n1;
            n2_in    = cnt_n2;
            m_in     = (bias_ff == bco_pkg::BIAS_GLOBAL) ? {n_eff, 1'b0}
                                                         : ({1'b0, cnt_n1} + {1'b0, cnt_n2});
            state_in = bco_pkg::S_MUL;
         end
         bco_pkg::S_MUL: begin
            prod_in  = PW'(r_val) * PW'(m_ff);
            state_in = bco_pkg::S_WIN;
         end
         bco_pkg::S_WIN: begin
            case (bias_ff)
               bco_pkg::BIAS_PAIRWISE: fw_in = pair_fw;
               bco_pkg::BIAS_GLOBAL:   fw_in = (n1_ff != n2_ff) ? major_fw : unbiased_fw;
               default:                fw_in = unbiased_fw;
            endcase
            win_in    = fw_in ? item_ff.first_agent : item_ff.second_agent;
            lose_in   = fw_in ? item_ff.second_agent : item_ff.first_agent;
            adopt_in  = qw;
            cnt_we    = 1'b1;
            cnt_waddr = OAW'(qw - OW'(1));
            cnt_wdata = (nw == bco_pkg::COUNT_MAX) ? nw : (nw + CW'(1));
            ag_we     = 1'b1;
            ag_waddr  = AAW'(lose_in);
            ag_wdata  = qw;
            state_in  = bco_pkg::S_LOSE;
         end
         bco_pkg::S_LOSE: begin
            cnt_we    = 1'b1;
            cnt_waddr = OAW'(ql - OW'(1));
            cnt_wdata = nl_dec;
            van_in    = (nl_dec == '0);
            if (nl_dec == '0) begin
               scan_idx_in = '0;
               any_in      = 1'b0;
               state_in    = bco_pkg::S_SCAN;
            end else begin
               state_in = bco_pkg::S_RESP;
            end
         end
         bco_pkg::S_SCAN: begin
            active_in[scan_idx_ff] = scan_act;
            any_in = any_ff || scan_act;
            if (scan_idx_ff == SCAN_LAST) begin
               steady_in = !(any_ff || scan_act);
               state_in  = bco_pkg::S_RESP;
            end else begin
               scan_idx_in = scan_idx_ff + OAW'(1);
            end
         end
         bco_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_item_in.status           = status_ff;
               rsp_item_in.winner_agent     = win_ff;
               rsp_item_in.loser_agent      = lose_ff;
               rsp_item_in.adopted_opinion  = adopt_ff;
               rsp_item_in.opinion_vanished = van_ff;
               rsp_item_in.steady           = steady_ff;
               state_in                     = bco_pkg::S_IDLE;
            end
         end
         default: state_in = bco_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bco_pkg::S_IDLE;
         scan_idx_ff  <= '0;
         any_ff       <= 1'b0;
         steady_ff    <= 1'b1;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         any_ff       <= any_in;
         steady_ff    <= steady_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      status_ff   <= status_in;
      win_ff      <= win_in;
      lose_ff     <= lose_in;
      adopt_ff    <= adopt_in;
      van_ff      <= van_in;
      q1_ff       <= q1_in;
      q2_ff       <= q2_in;
      n1_ff       <= n1_in;
      n2_ff       <= n2_in;
      m_ff        <= m_in;
      prod_ff     <= prod_in;
      fw_ff       <= fw_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_steady_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bco_pkg::S_SCAN) |-> (steady_ff == (active_ff == '0)))
      else $error("steady flag out of step with activity");

   a_active_has_agents: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bco_pkg::S_SCAN) |-> ((active_ff & ~nz) == '0))
      else $error("empty opinion marked active");

   a_scan_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bco_pkg::S_SCAN && scan_idx_ff != SCAN_LAST) |=>
      (scan_idx_ff == OAW'($past(scan_idx_ff) + OAW'(1))))
      else $error("activity walk skipped an opinion");
`endif

endmodule
`default_nettype wire
